### sv/dlt_pkg.sv
// dlt_pkg: shared types, codes and sizes of the lease table block
// no dependencies; used by dlt_lease_mem and dhcp_lease_table
package dlt_pkg;

   localparam int CLIENTS = 8;
   localparam int SLOT_W = (CLIENTS > 1) ? $clog2(CLIENTS) : 1;
   localparam int MAC_W = 48;
   localparam int EXP_W = 16;

   localparam logic [7:0]  BASE_RESET   = 8'd8;
   localparam logic [23:0] PREFIX_RESET = 24'd0;
   localparam logic [31:0] LEASE_RESET  = 32'd86400000;

   typedef enum logic [1:0] {
      CSR_BASE_OFFSET   = 2'd0,
      CSR_SUBNET_PREFIX = 2'd1,
      CSR_LEASE_MS      = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      KIND_NONE  = 2'd0,
      KIND_OFFER = 2'd1,
      KIND_ACK   = 2'd2
   } reply_kind_type;

   typedef enum logic [2:0] {
      DROP_OK          = 3'd0,
      DROP_TABLE_FULL  = 3'd1,
      DROP_NO_IP       = 3'd2,
      DROP_WRONG_NET   = 3'd3,
      DROP_OUT_OF_RANGE = 3'd4,
      DROP_OWNED       = 3'd5
   } drop_reason_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN_MAC,
      ST_SCAN_FREE,
      ST_REQ_CHECK,
      ST_REQ_EVAL,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [EXP_W-1:0] expiry;
      logic [MAC_W-1:0] mac;
   } lease_entry_type;

   typedef struct packed {
      logic              wr_en;
      logic [SLOT_W-1:0] wr_addr;
      lease_entry_type   wr_data;
      logic [SLOT_W-1:0] rd_addr;
   } mem_cmd_type;

endpackage

### sv/dlt_lease_mem.sv
// dlt_lease_mem: lease slot memory, one write and one registered read per cycle
// per-slot valid bits make unwritten slots read as empty; uses dlt_pkg
module dlt_lease_mem (
   input  logic                     clock,
   input  logic                     reset,
   input  dlt_pkg::mem_cmd_type     cmd,
   output dlt_pkg::lease_entry_type rd_data
);

   dlt_pkg::lease_entry_type            mem [dlt_pkg::CLIENTS];
   logic [dlt_pkg::CLIENTS-1:0]         valid_ff;
   dlt_pkg::lease_entry_type            rd_raw_ff;
   logic                                rd_vld_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[cmd.wr_addr] <= cmd.wr_data;
      end
      rd_raw_ff <= mem[cmd.rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (cmd.wr_en) begin
            valid_ff[cmd.wr_addr] <= 1'b1;
         end
         rd_vld_ff <= valid_ff[cmd.rd_addr];
      end
   end

   assign rd_data = rd_vld_ff ? rd_raw_ff : '0;

endmodule

### sv/dhcp_lease_table.sv
// dhcp_lease_table: lease allocation core, top level
// uses dlt_pkg and dlt_lease_mem
//
// req channel: one beat per message, tuser = func (0 discover, 1 request),
//   tdata = hw_addr, ip_present, ip_want, now_ms.
// rsp channel: exactly one beat per req beat, in order, tuser = reply_kind,
//   tdata = host_byte, slot, drop_reason.
// csr channel: always ready; index 0 base_offset, 1 subnet_prefix,
//   2 lease_ms; other indexes are ignored. Write only while idle.
// One message at a time. A request passes through ST_REQ_CHECK and ST_REQ_EVAL
// to ST_DONE, and goes from ST_REQ_CHECK straight to ST_DONE when it is refused
// on the address checks. A discover scans the table for its MAC and ends on a
// hit; a miss scans the table a second time for a free slot. The scans read
// the slot memory one slot per cycle through its registered read port.
// req_tready rises again in the cycle the result enters the output register.
// A result waiting on a stalled rsp side sits in the output register while
// the next message is accepted; that message finishes and then waits until
// the output register frees.
// Reset is synchronous: control and csr registers return to their reset
// values, and all slots read as empty at once.
module dhcp_lease_table (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   // [47:0] hw_addr, [48] ip_present, [80:49] ip_want,
   // [112:81] now_ms, [119:113] zero
   input  logic [119:0]  req_tdata,
   // [0] func
   input  logic [0:0]    req_tuser,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // [7:0] host_byte, [15:8] slot, [18:16] drop_reason, [23:19] zero
   output logic [23:0]   rsp_tdata,
   // [1:0] reply_kind
   output logic [1:0]    rsp_tuser,
   input  logic          csr_valid,
   output logic          csr_ready,
   input  logic [1:0]    csr_index,
   input  logic [31:0]   csr_data
);

   localparam logic [dlt_pkg::SLOT_W-1:0] LAST_SLOT =
      dlt_pkg::SLOT_W'(dlt_pkg::CLIENTS - 1);

   dlt_pkg::state_type        state_ff, state_in;

   logic [7:0]                base_ff;
   logic [23:0]               prefix_ff;
   logic [31:0]               lease_ff;

   logic                      func_ff, func_in;
   logic [47:0]               mac_ff, mac_in;
   logic                      has_ip_ff, has_ip_in;
   logic [31:0]               ip_ff, ip_in;
   logic [31:0]               now_ff, now_in;

   logic [dlt_pkg::SLOT_W-1:0] cnt_ff, cnt_in;
   logic [dlt_pkg::SLOT_W-1:0] chk_idx_ff, chk_idx_in;
   logic                      chk_vld_ff, chk_vld_in;

   dlt_pkg::reply_kind_type   res_kind_ff, res_kind_in;
   logic [7:0]                res_host_ff, res_host_in;
   logic [7:0]                res_slot_ff, res_slot_in;
   dlt_pkg::drop_reason_type  res_reason_ff, res_reason_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   dlt_pkg::reply_kind_type   rsp_kind_ff, rsp_kind_in;
   logic [7:0]                rsp_host_ff, rsp_host_in;
   logic [7:0]                rsp_slot_ff, rsp_slot_in;
   dlt_pkg::drop_reason_type  rsp_reason_ff, rsp_reason_in;

   dlt_pkg::mem_cmd_type      mem_cmd;
   dlt_pkg::lease_entry_type  rd_data;

   logic                      req_accept;
   logic                      out_free;
   logic                      chk_last;
   logic                      expired;
   logic                      mac_hit;
   logic                      free_hit;
   logic                      owned;
   logic [7:0]                req_host;
   logic [7:0]                req_idx;
   logic                      req_bad;
   dlt_pkg::drop_reason_type  req_reason;
   logic [15:0]               new_expiry;
   logic [31:0]               expiry_sum;

   dlt_lease_mem u_mem (
      .clock   (clock),
      .reset   (reset),
      .cmd     (mem_cmd),
      .rd_data (rd_data)
   );

   assign csr_ready  = 1'b1;
   assign req_tready = (state_ff == dlt_pkg::ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   assign chk_last = (chk_idx_ff == LAST_SLOT);
   assign expired  = (rd_data.expiry < now_ff[31:16]);
   assign mac_hit  = chk_vld_ff && (rd_data.mac == mac_ff);
   assign free_hit = chk_vld_ff && ((rd_data.mac == '0) || expired);
   assign owned    = (rd_data.mac != mac_ff) && (rd_data.mac != '0) && !expired;

   assign req_host = ip_ff[7:0];
   assign req_idx  = req_host - base_ff;
   assign expiry_sum = now_ff + lease_ff;
   assign new_expiry = expiry_sum[31:16];

   always_comb begin
      req_bad    = 1'b1;
      req_reason = dlt_pkg::DROP_OK;
      priority if (!has_ip_ff) begin
         req_reason = dlt_pkg::DROP_NO_IP;
      end else if (ip_ff[31:8] != prefix_ff) begin
         req_reason = dlt_pkg::DROP_WRONG_NET;
      end else if (req_idx >= 8'(dlt_pkg::CLIENTS)) begin
         req_reason = dlt_pkg::DROP_OUT_OF_RANGE;
      end else begin
         req_bad = 1'b0;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         dlt_pkg::ST_IDLE: begin
            if (req_accept) begin
               state_in = req_tuser[0] ? dlt_pkg::ST_REQ_CHECK : dlt_pkg::ST_SCAN_MAC;
            end
         end
         dlt_pkg::ST_SCAN_MAC: begin
            priority if (mac_hit) begin
               state_in = dlt_pkg::ST_DONE;
            end else if (chk_vld_ff && chk_last) begin
               state_in = dlt_pkg::ST_SCAN_FREE;
            end else begin
            end
         end
         dlt_pkg::ST_SCAN_FREE: begin
            if (free_hit || (chk_vld_ff && chk_last)) begin
               state_in = dlt_pkg::ST_DONE;
            end
         end
         dlt_pkg::ST_REQ_CHECK: begin
            state_in = req_bad ? dlt_pkg::ST_DONE : dlt_pkg::ST_REQ_EVAL;
         end
         dlt_pkg::ST_REQ_EVAL: begin
            state_in = dlt_pkg::ST_DONE;
         end
         dlt_pkg::ST_DONE: begin
            if (out_free) begin
               state_in = dlt_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = dlt_pkg::ST_IDLE;
         end
      endcase
   end

   // datapath and memory commands
   always_comb begin
      func_in       = func_ff;
      mac_in        = mac_ff;
      has_ip_in     = has_ip_ff;
      ip_in         = ip_ff;
      now_in        = now_ff;
      cnt_in        = cnt_ff;
      chk_idx_in    = chk_idx_ff;
      chk_vld_in    = chk_vld_ff;
      res_kind_in   = res_kind_ff;
      res_host_in   = res_host_ff;
      res_slot_in   = res_slot_ff;
      res_reason_in = res_reason_ff;
      mem_cmd.wr_en          = 1'b0;
      mem_cmd.wr_addr        = chk_idx_ff;
      mem_cmd.wr_data.expiry = rd_data.expiry;
      mem_cmd.wr_data.mac    = mac_ff;
      mem_cmd.rd_addr        = cnt_ff;

      unique case (state_ff)
         dlt_pkg::ST_IDLE: begin
            cnt_in     = '0;
            chk_vld_in = 1'b0;
            if (req_accept) begin
               func_in   = req_tuser[0];
               mac_in    = req_tdata[47:0];
               has_ip_in = req_tdata[48];
               ip_in     = req_tdata[80:49];
               now_in    = req_tdata[112:81];
            end
         end
         dlt_pkg::ST_SCAN_MAC, dlt_pkg::ST_SCAN_FREE: begin
            chk_vld_in = 1'b1;
            chk_idx_in = cnt_ff;
            if (cnt_ff != LAST_SLOT) begin
               cnt_in = cnt_ff + 1'b1;
            end
            priority if ((state_ff == dlt_pkg::ST_SCAN_MAC) ? mac_hit : free_hit) begin
               mem_cmd.wr_en = (state_ff == dlt_pkg::ST_SCAN_FREE);
               res_kind_in   = dlt_pkg::KIND_OFFER;
               res_host_in   = base_ff + 8'(chk_idx_ff);
               res_slot_in   = 8'(chk_idx_ff);
               res_reason_in = dlt_pkg::DROP_OK;
            end else if (chk_vld_ff && chk_last) begin
               cnt_in        = '0;
               chk_vld_in    = 1'b0;
               res_kind_in   = dlt_pkg::KIND_NONE;
               res_host_in   = '0;
               res_slot_in   = '0;
               res_reason_in = dlt_pkg::DROP_TABLE_FULL;
            end else begin
            end
         end
         dlt_pkg::ST_REQ_CHECK: begin
            mem_cmd.rd_addr = req_idx[dlt_pkg::SLOT_W-1:0];
            res_kind_in     = dlt_pkg::KIND_NONE;
            res_host_in     = '0;
            res_slot_in     = '0;
            res_reason_in   = req_reason;
         end
         dlt_pkg::ST_REQ_EVAL: begin
            mem_cmd.wr_addr        = req_idx[dlt_pkg::SLOT_W-1:0];
            mem_cmd.wr_data.expiry = new_expiry;
            if (owned) begin
               res_reason_in = dlt_pkg::DROP_OWNED;
            end else begin
               mem_cmd.wr_en = 1'b1;
               res_kind_in   = dlt_pkg::KIND_ACK;
               res_host_in   = req_host;
               res_slot_in   = req_idx;
               res_reason_in = dlt_pkg::DROP_OK;
            end
         end
         dlt_pkg::ST_DONE: begin
         end
         default: begin
         end
      endcase
   end

   // output register
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_kind_in   = rsp_kind_ff;
      rsp_host_in   = rsp_host_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_reason_in = rsp_reason_ff;
      priority if ((state_ff == dlt_pkg::ST_DONE) && out_free) begin
         rsp_valid_in  = 1'b1;
         rsp_kind_in   = res_kind_ff;
         rsp_host_in   = res_host_ff;
         rsp_slot_in   = res_slot_ff;
         rsp_reason_in = res_reason_ff;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dlt_pkg::ST_IDLE;
         base_ff      <= dlt_pkg::BASE_RESET;
         prefix_ff    <= dlt_pkg::PREFIX_RESET;
         lease_ff     <= dlt_pkg::LEASE_RESET;
         cnt_ff       <= '0;
         chk_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         chk_vld_ff   <= chk_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               dlt_pkg::CSR_BASE_OFFSET:   base_ff   <= csr_data[7:0];
               dlt_pkg::CSR_SUBNET_PREFIX: prefix_ff <= csr_data[23:0];
               dlt_pkg::CSR_LEASE_MS:      lease_ff  <= csr_data;
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      func_ff       <= func_in;
      mac_ff        <= mac_in;
      has_ip_ff     <= has_ip_in;
      ip_ff         <= ip_in;
      now_ff        <= now_in;
      chk_idx_ff    <= chk_idx_in;
      res_kind_ff   <= res_kind_in;
      res_host_ff   <= res_host_in;
      res_slot_ff   <= res_slot_in;
      res_reason_ff <= res_reason_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_host_ff   <= rsp_host_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_reason_ff <= rsp_reason_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tdata  = {5'd0, rsp_reason_ff, rsp_slot_ff, rsp_host_ff};

`ifndef SYNTHESIS
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> !req_tready)
      else $error("beat accepted while a message is in progress");

   a_write_phase: assert property (@(posedge clock) disable iff (reset)
      mem_cmd.wr_en |-> (state_ff == dlt_pkg::ST_SCAN_FREE) ||
                        (state_ff == dlt_pkg::ST_REQ_EVAL))
      else $error("slot write outside of a binding phase");

   a_kind_reason: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((rsp_kind_ff == dlt_pkg::KIND_NONE) ==
                        (rsp_reason_ff != dlt_pkg::DROP_OK)))
      else $error("reply kind and drop reason disagree");

   a_kind_func: assert property (@(posedge clock) disable iff (reset)
      (state_ff == dlt_pkg::ST_DONE) && (res_kind_ff != dlt_pkg::KIND_NONE) |->
         ((res_kind_ff == dlt_pkg::KIND_ACK) == func_ff))
      else $error("reply kind does not match the message kind");

   a_slot_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_kind_ff != dlt_pkg::KIND_NONE) |->
         (rsp_slot_ff < 8'(dlt_pkg::CLIENTS)))
      else $error("reply names a slot beyond the table");
`endif

endmodule
